### design/sam_pkg.sv
package sam_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Field widths and stream widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int IN_RAW_W = OP_W + 2 * ADDR_W;
  localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 1 + STATUS_W + COUNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_MASK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture request, clear scan index and hit flag
    logic rd_en;     // read table at scan index, advance index
    logic out_load;  // commit table update and load result register
  } sam_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scan;  // check request with a non-empty table
    logic scan_last;  // scan index points at the last held entry
    logic out_busy;   // result register holds an untaken result
  } sam_stat_t;

endpackage

### design/sam_ctrl.sv
module sam_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  sam_pkg::sam_stat_t stat,
  output sam_pkg::sam_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    PREP,
    SCAN,
    DRAIN,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    case (state)
      IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = PREP;
        end
      end
      PREP: begin
        state_next = stat.need_scan ? SCAN : FINISH;
      end
      SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.scan_last) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        // last read entry is compared this cycle
        state_next = FINISH;
      end
      FINISH: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

### design/sam_dp.sv
module sam_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sam_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [sam_pkg::OUT_W-1:0] m_tdata,
  input  sam_pkg::sam_cmd_t         cmd,
  output sam_pkg::sam_stat_t        stat
);

  localparam int CW = sam_pkg::COUNT_W;
  localparam int IW = sam_pkg::IDX_W;
  localparam int AW = sam_pkg::ADDR_W;

  typedef logic [sam_pkg::OUT_W-1:0] out_word_t;

  // Request registers
  logic [sam_pkg::OP_W-1:0] op;
  logic [AW-1:0]            addr;
  logic [AW-1:0]            mask;

  // Table storage and count
  logic [AW-1:0] mask_mem [sam_pkg::TABLE_DEPTH];
  logic [AW-1:0] net_mem  [sam_pkg::TABLE_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Scan state
  logic [IW-1:0] idx;
  logic [AW-1:0] rd_mask;
  logic [AW-1:0] rd_net;
  logic          rd_valid;
  logic          hit;

  // Result fields
  logic                         allowed;
  logic [sam_pkg::STATUS_W-1:0] status;
  logic                         wr_en;
  logic                         bad_mask;
  logic                         full;

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= s_tdata[sam_pkg::OP_W-1:0];
      addr <= s_tdata[sam_pkg::OP_W +: AW];
      mask <= s_tdata[sam_pkg::OP_W + AW +: AW];
    end
  end

  // Table read port, registered data
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_mask <= mask_mem[idx];
      rd_net  <= net_mem[idx];
    end
  end

  // Table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mask_mem[count[IW-1:0]] <= mask;
      net_mem[count[IW-1:0]]  <= addr;
    end
  end

  // Scan index, compare and hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.load) begin
        idx <= '0;
        hit <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          idx <= idx + 1'b1;
        end
        if (rd_valid && ((addr & rd_mask) == rd_net)) begin
          hit <= 1'b1;
        end
      end
    end
  end

  // Result and table update
  always_comb begin
    bad_mask   = (addr & mask) != addr;
    full       = count >= CW'(sam_pkg::TABLE_DEPTH);
    allowed    = 1'b0;
    status     = sam_pkg::ST_OK;
    wr_en      = 1'b0;
    count_next = count;
    case (op)
      sam_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      sam_pkg::OP_INSERT: begin
        if (bad_mask) begin
          status = sam_pkg::ST_BAD_MASK;
        end else if (full) begin
          status = sam_pkg::ST_FULL;
        end else begin
          wr_en      = cmd.out_load;
          count_next = count + 1'b1;
        end
      end
      sam_pkg::OP_CHECK: begin
        allowed = (count == '0) || hit;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.out_load) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= out_word_t'({count_next, status, allowed});
    end
  end

  // Status to controller
  always_comb begin
    stat.need_scan = (op == sam_pkg::OP_CHECK) && (count != '0);
    stat.scan_last = (CW'(idx) + 1'b1) == count;
    stat.out_busy  = m_tvalid && !m_tready;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(sam_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_read_held: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (CW'(idx) < count))
    else $error("scan reads beyond held entries");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !stat.out_busy)
    else $error("result loaded over an untaken result");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result register not valid after load");

endmodule

### design/subnet_access_list_match_core.sv
// Subnet access list match core.
// Holds up to 16 (mask, network) pairs and answers clear, insert and check
// requests, one result per request.
// Request channel s_*: accepted when s_tvalid and s_tready are high at a
// rising edge. s_tready is high only while the controller is idle.
// Result channel m_*: one registered result; a new request is taken while a
// finished result still waits in it.
// Sequence: a clear, an insert, or a check against an empty table goes
// from PREP to FINISH; a check against held entries scans them first,
// one table read per entry through the single read port, then drains.
// A new request can be accepted the cycle after a result is loaded; the
// block takes no new request before the last one's result is loaded.
// If the receiver stalls, the controller holds the finished request until
// the result register frees, and accepts nothing meanwhile.
// Reset (rst, synchronous) empties the table and drops any pending result;
// table contents are not cleared, entries are only read below the count.
module subnet_access_list_match_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [sam_pkg::IN_W-1:0]  s_tdata,  // operation, address, net_mask, zero pad
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [sam_pkg::OUT_W-1:0] m_tdata   // allowed, status, entry_count
);

  sam_pkg::sam_cmd_t  cmd;
  sam_pkg::sam_stat_t stat;

  sam_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sam_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

### tb/subnet_access_list_match_core_tb.sv
module subnet_access_list_match_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the block must ignore
  localparam logic [sam_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_REQUESTS = 1500;

  typedef struct packed {
    logic                         allowed;
    logic [sam_pkg::STATUS_W-1:0] status;
    logic [sam_pkg::COUNT_W-1:0]  count;
  } verdict_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [sam_pkg::IN_W-1:0]  s_tdata = '0;   // operation, address, net_mask, zero pad
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [sam_pkg::OUT_W-1:0] m_tdata;        // allowed, status, entry_count

  // Shadow copy of the access list
  logic [sam_pkg::ADDR_W-1:0] rule_mask [sam_pkg::TABLE_DEPTH];
  logic [sam_pkg::ADDR_W-1:0] rule_net  [sam_pkg::TABLE_DEPTH];
  int                         rule_count = 0;

  verdict_t verdict_q [$];
  int       fail_count = 0;
  int       requests_sent = 0;
  int       cycle_count = 0;
  bit       steady_flow = 1'b0;

  subnet_access_list_match_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Access list behavior: updates the shadow table, returns the verdict
  function automatic verdict_t apply_request(logic [sam_pkg::OP_W-1:0] op,
                                             logic [sam_pkg::ADDR_W-1:0] addr,
                                             logic [sam_pkg::ADDR_W-1:0] mask);
    verdict_t v;
    v = '0;
    case (op)
      sam_pkg::OP_CLEAR: begin
        rule_count = 0;
      end
      sam_pkg::OP_INSERT: begin
        if ((addr & mask) != addr) begin
          v.status = sam_pkg::ST_BAD_MASK;
        end else if (rule_count >= sam_pkg::TABLE_DEPTH) begin
          v.status = sam_pkg::ST_FULL;
        end else begin
          rule_mask[rule_count] = mask;
          rule_net[rule_count]  = addr;
          rule_count++;
        end
      end
      sam_pkg::OP_CHECK: begin
        // empty list admits everyone
        v.allowed = (rule_count == 0);
        for (int i = 0; i < rule_count; i++) begin
          if ((addr & rule_mask[i]) == rule_net[i]) v.allowed = 1'b1;
        end
      end
      default: ;
    endcase
    v.count = sam_pkg::COUNT_W'(rule_count);
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Send one request; s_tvalid stays high when the next one follows back to back
  task automatic send_request(logic [sam_pkg::OP_W-1:0] op,
                              logic [sam_pkg::ADDR_W-1:0] addr,
                              logic [sam_pkg::ADDR_W-1:0] mask);
    int gap;
    logic [sam_pkg::IN_W-1:0] word;
    gap = pick_gap();
    word = '0;
    word[0 +: sam_pkg::OP_W] = op;
    word[sam_pkg::OP_W +: sam_pkg::ADDR_W] = addr;
    word[sam_pkg::OP_W + sam_pkg::ADDR_W +: sam_pkg::ADDR_W] = mask;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    verdict_q.push_back(apply_request(op, addr, mask));
    requests_sent++;
  endtask

  // Hold off until every pending result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, mostly short
  initial begin
    int stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (steady_flow || r < 55) begin
        m_tready <= 1'b1;
      end else begin
        stall = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        m_tready <= 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.allowed = m_tdata[0];
      got.status  = m_tdata[1 +: sam_pkg::STATUS_W];
      got.count   = m_tdata[1 + sam_pkg::STATUS_W +: sam_pkg::COUNT_W];
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got.allowed !== want.allowed) begin
          $display("%0t: allowed expected %0d actual %0d", $time, want.allowed, got.allowed);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count, got.count);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [sam_pkg::ADDR_W-1:0] prefix_mask(int len);
    return sam_pkg::ADDR_W'(64'hFFFF_FFFF_0000_0000 >> len);
  endfunction

  // Empty list: checks pass, clear and unused codes leave it empty
  task automatic test_empty_table();
    send_request(sam_pkg::OP_CHECK, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(sam_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(sam_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(sam_pkg::OP_CHECK, $urandom, $urandom);
  endtask

  // Host rule, mask faults, full list, scan to the last entry
  task automatic test_table_limits();
    send_request(sam_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(sam_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'h0);
    send_request(sam_pkg::OP_CHECK, 32'h0000_0000, 32'h0);
    send_request(sam_pkg::OP_INSERT, 32'h0000_0001, 32'h0000_0000);
    for (int i = 1; i < sam_pkg::TABLE_DEPTH; i++) begin
      send_request(sam_pkg::OP_INSERT, {8'd10, 8'(i), 16'h0}, prefix_mask(16));
    end
    send_request(sam_pkg::OP_INSERT, 32'h0A63_0000, prefix_mask(16));
    // both faults at once: mask fault wins
    send_request(sam_pkg::OP_INSERT, 32'h0000_00FF, prefix_mask(24));
    send_request(sam_pkg::OP_CHECK, {8'd10, 8'(sam_pkg::TABLE_DEPTH - 1), 16'hBEEF}, 32'h0);
    send_request(sam_pkg::OP_CHECK, 32'h0B00_0001, 32'h0);
    send_request(OP_UNUSED, 32'h0A01_0000, 32'hFFFF_0000);
    send_request(sam_pkg::OP_CLEAR, 32'h0, 32'h0);
    send_request(sam_pkg::OP_CHECK, 32'h0B00_0001, 32'h0);
    // zero mask matches every address
    send_request(sam_pkg::OP_INSERT, 32'h0, 32'h0);
    send_request(sam_pkg::OP_CHECK, $urandom, 32'h0);
    wait_drained();
  endtask

  // Rule sets with matching checks, mixed with faults and noise
  task automatic test_random_traffic();
    int target;
    int k;
    int idx;
    int len;
    logic [sam_pkg::ADDR_W-1:0] m;
    logic [sam_pkg::ADDR_W-1:0] a;
    target = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < target) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 3) != 0) send_request(sam_pkg::OP_CLEAR, $urandom, $urandom);
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) begin
            m = $urandom;
          end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(16, 32);
            m = prefix_mask(len);
          end
          send_request(sam_pkg::OP_INSERT, $urandom & m, m);
        end
        repeat ($urandom_range(2, 10)) begin
          a = $urandom;
          if (rule_count > 0 && $urandom_range(0, 2) != 0) begin
            idx = $urandom_range(0, rule_count - 1);
            a = rule_net[idx] | ($urandom & ~rule_mask[idx]);
            // near miss on one mask bit
            if ($urandom_range(0, 3) == 0) a[$urandom_range(0, 31)] ^= 1'b1;
          end
          send_request(sam_pkg::OP_CHECK, a, $urandom);
        end
      end else begin
        repeat ($urandom_range(2, 6)) begin
          if ($urandom_range(0, 1) == 0) begin
            // insert with a network bit outside the mask
            idx = $urandom_range(0, 31);
            m = $urandom;
            m[idx] = 1'b0;
            a = $urandom;
            a[idx] = 1'b1;
            send_request(sam_pkg::OP_INSERT, a, m);
          end else begin
            send_request(sam_pkg::OP_W'($urandom_range(0, 3)), $urandom, $urandom);
          end
        end
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_table_limits();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
design/sam_pkg.sv
design/sam_ctrl.sv
design/sam_dp.sv
design/subnet_access_list_match_core.sv
tb/subnet_access_list_match_core_tb.sv
